/* hdl/gwwl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwwl_pkg
// Shared types and constants for the greedy word wrap layout block.
// ----------------------------------------------------------------------------
package gwwl_pkg;

   // field widths
   localparam int BYTE_W       = 8;
   localparam int LINE_W_W     = 10;
   localparam int CFG_LIMIT_W  = 6;
   localparam int X_W          = 10;
   localparam int Y_W          = 8;
   localparam int START_W      = 12;
   localparam int LEN_W        = 8;

   // configuration port
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_BUDGET = 2'd1;

   localparam logic [LINE_W_W-1:0]    LINE_WIDTH_RST  = 10'd84;
   localparam logic [CFG_LIMIT_W-1:0] WORD_BUDGET_RST = 6'd32;

   // text and glyph geometry
   localparam logic [BYTE_W-1:0] SEP_MAX   = 8'h20;
   localparam logic [LEN_W-1:0]  CHARS_MAX = 8'd255;
   localparam logic [Y_W-1:0]    Y_PITCH   = 8'd6;
   localparam logic [Y_W-1:0]    Y_MAX     = 8'd252;
   localparam logic [Y_W-1:0]    H_PAD     = 8'd5;
   localparam logic [Y_W-1:0]    H_MAX     = 8'd255;
   localparam logic [X_W-1:0]    X_MAX     = 10'd1023;
   localparam int                GLYPH_ADV = 4;

   // record kinds
   localparam logic REC_WORD = 1'b0;
   localparam logic REC_BOX  = 1'b1;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [LINE_W_W-1:0]    line_width;
      logic [CFG_LIMIT_W-1:0] word_budget;
   } cfg_type;

   typedef struct packed {
      logic                record_kind;
      logic [X_W-1:0]      word_x;
      logic [Y_W-1:0]      word_y;
      logic [START_W-1:0]  word_start;
      logic [LEN_W-1:0]    word_length;
      logic [X_W-1:0]      text_width;
      logic [Y_W-1:0]      text_height;
      logic                last;
   } rec_type;

   typedef struct packed {
      logic    word_valid;
      logic    box_valid;
      rec_type word_rec;
      rec_type box_rec;
   } push_type;

endpackage

/* hdl/greedy_word_wrap_layout_top.sv */
`timescale 1ns / 1ps
// flow: a byte waits in the input beat register, laid out once the queue has room;
//   its records then wait in a four-entry queue until popped
// throughput: one byte per cycle while the queue has room for two; a byte that closes
//   a word and ends the text gives two records, popped one per cycle if not stalled
// reset: synchronous, clears all text state and queue, line_width 84, word budget 32
// ----------------------------------------------------------------------------
// greedy_word_wrap_layout_top
// Greedy word wrap of fixed-width text into word placements and a bounding box.
// ----------------------------------------------------------------------------
module greedy_word_wrap_layout_top #(
   parameter int MAX_WORDS      = 32,
   parameter int MAX_TEXT_BYTES = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   // text bytes
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [gwwl_pkg::BYTE_W-1:0]        req_char_byte,
   input  logic                               req_last_char,
   // records
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_record_kind,
   output logic [gwwl_pkg::X_W-1:0]           rsp_word_x,
   output logic [gwwl_pkg::Y_W-1:0]           rsp_word_y,
   output logic [gwwl_pkg::START_W-1:0]       rsp_word_start,
   output logic [gwwl_pkg::LEN_W-1:0]         rsp_word_length,
   output logic [gwwl_pkg::X_W-1:0]           rsp_text_width,
   output logic [gwwl_pkg::Y_W-1:0]           rsp_text_height,
   output logic                               rsp_last,
   // configuration
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gwwl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gwwl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gwwl_pkg::*;

   cfg_type            cfg_ff, cfg_in;
   logic               in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]  in_byte_ff, in_byte_in;
   logic               in_last_ff, in_last_in;
   logic               req_take;
   logic               advance;
   logic               room;
   logic               not_empty;
   logic               pop;
   push_type           push;
   rec_type            head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LINE_WIDTH:  cfg_in.line_width  = LINE_W_W'(csr_wdata);
            CSR_WORD_BUDGET: cfg_in.word_budget = csr_wdata[CFG_LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // input beat register; it moves on whenever the queue has room for two
   assign advance   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_char_byte;
         in_last_in  = req_last_char;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_width  <= LINE_WIDTH_RST;
         cfg_ff.word_budget <= WORD_BUDGET_RST;
         in_valid_ff        <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

   gwwl_layout #(
      .MAX_WORDS      (MAX_WORDS),
      .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
   ) u_layout (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .item_byte (in_byte_ff),
      .item_last (in_last_ff),
      .cfg       (cfg_ff),
      .push      (push)
   );

   assign pop = not_empty && !rsp_stall;

   gwwl_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .room      (room)
   );

   assign rsp_valid       = not_empty;
   assign rsp_record_kind = head.record_kind;
   assign rsp_word_x      = head.word_x;
   assign rsp_word_y      = head.word_y;
   assign rsp_word_start  = head.word_start;
   assign rsp_word_length = head.word_length;
   assign rsp_text_width  = head.text_width;
   assign rsp_text_height = head.text_height;
   assign rsp_last        = head.last;

endmodule

/* hdl/gwwl_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwwl_fifo
// Small result queue: takes up to two records a cycle, hands out one when popped.
// ----------------------------------------------------------------------------
module gwwl_fifo (
   input  logic               clock,
   input  logic               reset,
   input  gwwl_pkg::push_type push,
   input  logic               pop,
   output gwwl_pkg::rec_type  head,
   output logic               not_empty,
   output logic               room
);
   import gwwl_pkg::*;

   rec_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic [1:0]              n_push;
   logic [FIFO_PTR_W-1:0]   box_ptr;

   always_comb begin
      n_push    = {1'b0, push.word_valid} + {1'b0, push.box_valid};
      // box record lands behind the word record of the same byte
      box_ptr   = push.word_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.word_valid) begin
         mem_ff[wr_ptr_ff] <= push.word_rec;
      end
      if (push.box_valid) begin
         mem_ff[box_ptr] <= push.box_rec;
      end
   end

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign room      = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));

endmodule

/* hdl/gwwl_layout.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwwl_layout
// Word tracking, greedy placement and bounding box for one byte per cycle while step_en.
// ----------------------------------------------------------------------------
module gwwl_layout #(
   parameter int MAX_WORDS      = 32,
   parameter int MAX_TEXT_BYTES = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [gwwl_pkg::BYTE_W-1:0]   item_byte,
   input  logic                          item_last,
   input  gwwl_pkg::cfg_type             cfg,
   output gwwl_pkg::push_type            push
);
   import gwwl_pkg::*;

   localparam int WP_W  = $clog2(MAX_WORDS + 1);
   localparam int CMP_W = (WP_W > CFG_LIMIT_W) ? WP_W : CFG_LIMIT_W;
   localparam int POS_W = $clog2(MAX_TEXT_BYTES);

   logic [X_W-1:0]    cursor_x_ff, cursor_x_in;
   logic [Y_W-1:0]    cursor_y_ff, cursor_y_in;
   logic [WP_W-1:0]   words_ff, words_in;
   logic              inside_ff, inside_in;
   logic [POS_W-1:0]  start_ff, start_in;
   logic [LEN_W-1:0]  chars_ff, chars_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              limit_ff, limit_in;
   logic [X_W-1:0]    extent_x_ff, extent_x_in;
   logic [Y_W-1:0]    extent_y_ff, extent_y_in;

   logic              is_char;
   logic [POS_W-1:0]  w_start;
   logic [LEN_W-1:0]  w_chars;
   logic              finish;
   logic [CMP_W-1:0]  wl_ext, eff_lim;
   logic              limit_hit;
   logic              place;
   logic [WP_W-1:0]   words_inc;
   logic signed [12:0] wl_s, x_s, sub_full_s, sub_t_s, xz_s, nx_s;
   logic              trim, wrap;
   logic [LEN_W-1:0]  c_t;
   logic [X_W-1:0]    x_p, x_next;
   logic [Y_W:0]      y_step;
   logic [Y_W-1:0]    y_wrap, y_p;
   logic              ext_x_hit;
   logic [X_W-1:0]    ext_x_new;
   logic [Y_W-1:0]    ext_y_new;
   logic [Y_W:0]      h_sum;

   always_comb begin
      is_char = (item_byte > SEP_MAX);

      // word as it stands after this byte
      if (is_char && !inside_ff) begin
         w_start = pos_ff;
         w_chars = LEN_W'(1);
      end else if (is_char && chars_ff != CHARS_MAX) begin
         w_start = start_ff;
         w_chars = chars_ff + 1'b1;
      end else begin
         w_start = start_ff;
         w_chars = chars_ff;
      end

      finish = (is_char && item_last) || (!is_char && inside_ff);

      wl_ext = CMP_W'(cfg.word_budget);
      if (wl_ext == '0) begin
         eff_lim = CMP_W'(1);
      end else if (wl_ext > CMP_W'(MAX_WORDS)) begin
         eff_lim = CMP_W'(MAX_WORDS);
      end else begin
         eff_lim = wl_ext;
      end
      limit_hit = limit_ff || (CMP_W'(words_ff) >= eff_lim);
      place     = finish && !limit_hit;
      words_inc = words_ff + 1'b1;

      // width of c glyphs is c*4-1; a trimmed word may come out at -1
      wl_s       = $signed({3'b000, cfg.line_width});
      x_s        = $signed({3'b000, cursor_x_ff});
      sub_full_s = $signed({3'b000, w_chars, 2'b00}) - 13'sd1;
      trim       = (sub_full_s > wl_s);
      c_t        = trim ? cfg.line_width[LINE_W_W-1:2] : w_chars;
      sub_t_s    = $signed({3'b000, c_t, 2'b00}) - 13'sd1;
      wrap       = ((x_s + sub_t_s) > wl_s);

      x_p    = wrap ? '0 : cursor_x_ff;
      y_step = {1'b0, cursor_y_ff} + {1'b0, Y_PITCH};
      y_wrap = (y_step > {1'b0, Y_MAX}) ? Y_MAX : y_step[Y_W-1:0];
      y_p    = wrap ? y_wrap : cursor_y_ff;

      xz_s      = $signed({3'b000, x_p}) + sub_t_s;
      ext_x_hit = (xz_s > $signed({3'b000, extent_x_ff}));
      nx_s      = xz_s + $signed(13'(GLYPH_ADV));
      x_next    = (nx_s > $signed({3'b000, X_MAX})) ? X_MAX : nx_s[X_W-1:0];

      ext_x_new = (place && ext_x_hit) ? xz_s[X_W-1:0] : extent_x_ff;
      ext_y_new = (place && y_p > extent_y_ff) ? y_p : extent_y_ff;
      h_sum     = {1'b0, ext_y_new} + {1'b0, H_PAD};

      // result records
      push                      = '0;
      push.word_valid           = step_en && place;
      push.word_rec.record_kind = REC_WORD;
      push.word_rec.word_x      = x_p;
      push.word_rec.word_y      = y_p;
      push.word_rec.word_start  = START_W'(w_start);
      push.word_rec.word_length = c_t;
      push.box_valid            = step_en && item_last;
      push.box_rec.record_kind  = REC_BOX;
      push.box_rec.text_width   = (ext_x_new == '0) ? X_W'(1) : ext_x_new;
      push.box_rec.text_height  = (h_sum > {1'b0, H_MAX}) ? H_MAX : h_sum[Y_W-1:0];
      push.box_rec.last         = 1'b1;

      // next state
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      words_in    = words_ff;
      inside_in   = (is_char || inside_ff) && !finish;
      start_in    = w_start;
      chars_in    = w_chars;
      pos_in      = (pos_ff < POS_W'(MAX_TEXT_BYTES - 1)) ? pos_ff + 1'b1 : pos_ff;
      limit_in    = limit_ff;
      extent_x_in = ext_x_new;
      extent_y_in = ext_y_new;
      if (finish && limit_hit) begin
         limit_in = 1'b1;
      end
      if (place) begin
         cursor_x_in = x_next;
         cursor_y_in = y_p;
         words_in    = words_inc;
         limit_in    = (CMP_W'(words_inc) >= eff_lim);
      end
      // a new text starts after the last byte
      if (item_last) begin
         cursor_x_in = '0;
         cursor_y_in = '0;
         words_in    = '0;
         inside_in   = 1'b0;
         start_in    = '0;
         chars_in    = '0;
         pos_in      = '0;
         limit_in    = 1'b0;
         extent_x_in = '0;
         extent_y_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
         words_ff    <= '0;
         inside_ff   <= 1'b0;
         start_ff    <= '0;
         chars_ff    <= '0;
         pos_ff      <= '0;
         limit_ff    <= 1'b0;
         extent_x_ff <= '0;
         extent_y_ff <= '0;
      end else if (step_en) begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         words_ff    <= words_in;
         inside_ff   <= inside_in;
         start_ff    <= start_in;
         chars_ff    <= chars_in;
         pos_ff      <= pos_in;
         limit_ff    <= limit_in;
         extent_x_ff <= extent_x_in;
         extent_y_ff <= extent_y_in;
      end
   end

`ifndef SYNTHESIS
   a_text_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && item_last |=> words_ff == '0 && cursor_x_ff == '0 && !inside_ff
                               && pos_ff == '0)
      else $error("text state not cleared after last byte");

   a_words_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(words_ff) <= CMP_W'(MAX_WORDS))
      else $error("word count beyond limit");

   a_y_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_y_ff <= Y_MAX && extent_y_ff <= Y_MAX)
      else $error("line y beyond its ceiling");

   a_box_once: assert property (@(posedge clock) disable iff (reset)
      push.box_valid == (step_en && item_last))
      else $error("bounding box record not tied to last byte");
`endif

endmodule
